[hdl/frame_table_lru_defines.svh]
// assertion macros for the frame table
`ifndef FRAME_TABLE_LRU_DEFINES_SVH
`define FRAME_TABLE_LRU_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked property, held off during reset
`define FTL_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// checked property, also during reset
`define FTL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);
`else
`define FTL_ASSERT(lbl, expr, msg)
`define FTL_ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

[hdl/ftl_pkg.sv]
package ftl_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int AGE_BITS_DEF = 16;

  // packed beat widths
  localparam int IN_W  = 48;
  localparam int OUT_W = 56;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_VICTIM = 3'd1,
    OP_AGE    = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } ftl_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } ftl_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RD_ADDR,
    S_RD_DATA,
    S_WRITE,
    S_FINISH
  } ftl_state_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic match;
    logic free;
    logic older;
  } ftl_step_t;

endpackage

[hdl/ftl_ram.sv]
module ftl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ftl_step_unit.sv]
module ftl_step_unit #(
  parameter int AGE_BITS = 16
) (
  input  logic                excluded,
  input  logic                ent_valid,
  input  logic [31:0]         ent_frame,
  input  logic [31:0]         key,
  input  logic [AGE_BITS-1:0] ent_age,
  input  logic [AGE_BITS-1:0] best_age,
  input  logic                have,
  output ftl_pkg::ftl_step_t  flags,
  output logic [AGE_BITS-1:0] new_age
);
  import ftl_pkg::*;

  always_comb begin
    flags.match = ent_valid && (ent_frame == key) && !excluded;
    flags.free  = !excluded && !ent_valid;
    flags.older = !excluded && (!have || (ent_age > best_age));
  end

  // saturating age step, cleared for the touched entry
  always_comb begin
    if (excluded) begin
      new_age = '0;
    end else if (ent_age == {AGE_BITS{1'b1}}) begin
      new_age = ent_age;
    end else begin
      new_age = ent_age + AGE_BITS'(1);
    end
  end

endmodule

[hdl/frame_table_lru.sv]
// flow: accept, decode, then lookup, victim and age scan the n active entries (a lookup hit
//   or free victim ends the scan early); read goes through address and data states, write
//   through the write state, bad index or unknown opcode straight to finish
// items: one at a time, no new beat is taken until the result is handed off; the scan runs
//   once over the entry rams, one entry per cycle through one shared compare and age unit
// reset: synchronous, clears valid and age-written marks, active_entries to 16
`include "frame_table_lru_defines.svh"

module frame_table_lru #(
  parameter int ENTRIES  = ftl_pkg::ENTRIES_DEF,
  parameter int AGE_BITS = ftl_pkg::AGE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wen,
  input  logic [4:0]               cfg_wdata,   // active_entries
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // opcode[2:0], frame_number[34:3], entry_index[38:35], except_index[42:39],
  // except_used[43], zero fill
  input  logic [ftl_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status[1:0], found_index[5:2], entry_frame[37:6], entry_valid[38],
  // entry_age[54:39], zero fill
  output logic [ftl_pkg::OUT_W-1:0] m_tdata
);
  import ftl_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  ftl_state_t state, state_next;

  logic [4:0]          active_q;
  logic [CNT_W-1:0]    n_act;

  // latched beat fields
  logic [2:0]          op_q;
  logic [31:0]         key_q;
  logic [3:0]          ei_q;
  logic [3:0]          xi_q;
  logic                xu_q;

  // scan control
  logic [CNT_W-1:0]    cnt;
  logic                pipe_v;
  logic [IDX_W-1:0]    pipe_idx;
  logic                issue;
  logic                scan_stop;
  logic                scan_end;
  logic                ei_ok;
  logic                out_free;

  // per-entry marks, one flop each
  logic [ENTRIES-1:0]  valid_q;
  logic [ENTRIES-1:0]  age_init_q;

  // running best for victim search
  logic                have;
  logic [AGE_BITS-1:0] best_age;
  logic [IDX_W-1:0]    best_idx;
  logic [31:0]         best_frame;

  // pending result
  logic [1:0]          res_status;
  logic [3:0]          res_idx;
  logic [31:0]         res_frame;
  logic                res_valid;
  logic [15:0]         res_age;

  // ram ports
  logic [IDX_W-1:0]    rd_addr;
  logic                frame_we;
  logic [31:0]         frame_rd;
  logic                age_we;
  logic [IDX_W-1:0]    age_waddr;
  logic [AGE_BITS-1:0] age_wdata;
  logic [AGE_BITS-1:0] age_rd;

  // entry under the scan, masked by marks so unwritten words read as zero
  logic                ent_valid;
  logic [31:0]         ent_frame;
  logic [AGE_BITS-1:0] ent_age;
  logic                excluded;
  ftl_step_t           flags;
  logic [AGE_BITS-1:0] new_age;

  // active count clamped to the table size
  always_comb begin
    if (32'(active_q) > 32'(ENTRIES)) begin
      n_act = CNT_W'(ENTRIES);
    end else begin
      n_act = CNT_W'(active_q);
    end
  end

  assign ei_ok     = 32'(ei_q) < 32'(n_act);
  assign out_free  = !m_tvalid || m_tready;

  assign ent_valid = valid_q[pipe_idx];
  assign ent_frame = ent_valid ? frame_rd : '0;
  assign ent_age   = age_init_q[pipe_idx] ? age_rd : '0;
  assign excluded  = xu_q && (32'(pipe_idx) == 32'(xi_q));

  // lookup stops on a match, victim on a free entry
  assign scan_stop = pipe_v && (((op_q == OP_LOOKUP) && flags.match) ||
                                ((op_q == OP_VICTIM) && flags.free));
  assign issue     = (state == S_SCAN) && (cnt < n_act) && !scan_stop;
  assign scan_end  = scan_stop || (!pipe_v && !(cnt < n_act));

  ftl_step_unit #(
    .AGE_BITS (AGE_BITS)
  ) u_step (
    .excluded  (excluded),
    .ent_valid (ent_valid),
    .ent_frame (ent_frame),
    .key       (key_q),
    .ent_age   (ent_age),
    .best_age  (best_age),
    .have      (have),
    .flags     (flags),
    .new_age   (new_age)
  );

  ftl_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_we),
    .waddr (IDX_W'(ei_q)),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (frame_rd)
  );

  ftl_ram #(
    .WIDTH (AGE_BITS),
    .DEPTH (ENTRIES)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (rd_addr),
    .rdata (age_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (op_q)
          OP_LOOKUP, OP_VICTIM, OP_AGE: state_next = S_SCAN;
          OP_WRITE: state_next = ei_ok ? S_WRITE : S_FINISH;
          OP_READ:  state_next = ei_ok ? S_RD_ADDR : S_FINISH;
          default:  state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_RD_ADDR: state_next = S_RD_DATA;
      S_RD_DATA: state_next = S_FINISH;
      S_WRITE:   state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == S_IDLE);
    rd_addr   = (state == S_RD_ADDR) ? IDX_W'(ei_q) : cnt[IDX_W-1:0];
    frame_we  = (state == S_WRITE);
    age_we    = 1'b0;
    age_waddr = pipe_idx;
    age_wdata = new_age;
    case (state)
      S_WRITE: begin
        age_we    = 1'b1;
        age_waddr = IDX_W'(ei_q);
        age_wdata = '0;
      end
      S_SCAN: begin
        age_we = pipe_v && (op_q == OP_AGE);
      end
      default: begin
        age_we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active_q   <= 5'd16;
      m_tvalid   <= 1'b0;
      valid_q    <= '0;
      age_init_q <= '0;
      pipe_v     <= 1'b0;
      have       <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        active_q <= cfg_wdata;
      end
      // a new result replaces one taken at the same edge
      if ((state == S_FINISH) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_DECODE: begin
          cnt    <= '0;
          pipe_v <= 1'b0;
          have   <= 1'b0;
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          pipe_v <= issue;
          if (pipe_v && (op_q == OP_VICTIM) && flags.older) begin
            have <= 1'b1;
          end
          if (age_we) begin
            age_init_q[pipe_idx] <= 1'b1;
          end
        end
        S_WRITE: begin
          valid_q[IDX_W'(ei_q)]    <= 1'b1;
          age_init_q[IDX_W'(ei_q)] <= 1'b1;
        end
        default: begin
          pipe_v <= 1'b0;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q  <= s_tdata[2:0];
      key_q <= s_tdata[34:3];
      ei_q  <= s_tdata[38:35];
      xi_q  <= s_tdata[42:39];
      xu_q  <= s_tdata[43];
    end
    case (state)
      S_DECODE: begin
        res_idx   <= '0;
        res_frame <= '0;
        res_valid <= 1'b0;
        res_age   <= '0;
        case (op_q)
          OP_LOOKUP, OP_VICTIM: res_status <= ST_NONE;
          OP_AGE:               res_status <= ST_OK;
          OP_WRITE, OP_READ:    res_status <= ei_ok ? ST_OK : ST_RANGE;
          default:              res_status <= ST_NONE;
        endcase
      end
      S_SCAN: begin
        if (issue) begin
          pipe_idx <= cnt[IDX_W-1:0];
        end
        if (scan_stop) begin
          // match or free entry: report the entry under the scan
          res_status <= ST_OK;
          res_idx    <= 4'(pipe_idx);
          res_frame  <= ent_frame;
          res_valid  <= ent_valid;
          res_age    <= 16'(ent_age);
        end else if (pipe_v && (op_q == OP_VICTIM) && flags.older) begin
          best_age   <= ent_age;
          best_idx   <= pipe_idx;
          best_frame <= ent_frame;
        end else if (scan_end && (op_q == OP_VICTIM) && have) begin
          // no free entry: oldest valid one, every candidate seen is valid
          res_status <= ST_OK;
          res_idx    <= 4'(best_idx);
          res_frame  <= best_frame;
          res_valid  <= 1'b1;
          res_age    <= 16'(best_age);
        end
      end
      S_RD_ADDR: begin
        pipe_idx <= IDX_W'(ei_q);
      end
      S_RD_DATA: begin
        res_idx   <= 4'(pipe_idx);
        res_frame <= ent_frame;
        res_valid <= ent_valid;
        res_age   <= 16'(ent_age);
      end
      S_WRITE: begin
        res_idx   <= ei_q;
        res_frame <= key_q;
        res_valid <= 1'b1;
        res_age   <= '0;
      end
      S_FINISH: begin
        if (out_free) begin
          m_tdata <= {1'b0, res_age, res_valid, res_frame, res_idx, res_status};
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // a taken beat closes the input side: ready is low once the beat is accepted
  `FTL_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")
  // a result that reports no entry carries zero fields
  `FTL_ASSERT(a_empty_result, (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[55:2] == '0),
              "nonzero fields without entry")
  // an entry marked valid always has its age word written
  `FTL_ASSERT(a_valid_has_age, (valid_q & ~age_init_q) == '0, "valid entry without age")
  // no scan data left in flight once idle
  `FTL_ASSERT(a_idle_pipe_empty, (state == S_IDLE) |-> !pipe_v, "scan pipe busy in idle")

endmodule

[sim/tb.sv]
module tb;
  import ftl_pkg::*;

  localparam int OPCODE_MAX = 7;
  localparam int GAP_MAX    = 17;
  localparam int SETTLE_CYC = 25;

  // input beat, lowest field last so opcode lands in bit 0
  typedef struct packed {
    logic        except_used;
    logic [3:0]  except_index;
    logic [3:0]  entry_index;
    logic [31:0] frame_number;
    logic [2:0]  opcode;
  } op_item_t;

  // result beat, status in the low bits
  typedef struct packed {
    logic [15:0] entry_age;
    logic        entry_valid;
    logic [31:0] entry_frame;
    logic [3:0]  found_index;
    logic [1:0]  status;
  } result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wen = 1'b0;
  logic [4:0]       cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b1;
  logic [OUT_W-1:0] m_tdata;

  // shadow copy of the frame table
  logic [31:0] frames_m [ENTRIES_DEF];
  logic        valid_m  [ENTRIES_DEF];
  logic [15:0] ages_m   [ENTRIES_DEF];
  logic [4:0]  active_cnt = 5'd16;

  result_t     pending_results[$];
  logic [31:0] frame_pool[8];
  int          errors = 0;
  bit          no_idle = 0;

  frame_table_lru uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("frame_table_lru: mismatch");
    $finish;
  end

  function automatic int active_limit();
    return (active_cnt > ENTRIES_DEF) ? ENTRIES_DEF : int'(active_cnt);
  endfunction

  // applies one operation to the shadow table and returns the result beat
  function automatic result_t table_apply(op_item_t it);
    result_t r;
    int      n;
    int      sel;
    int      best;
    bit      have;
    bit      found;
    bit      xu;
    int      xi;
    int      ei;
    n     = active_limit();
    sel   = -1;
    best  = 0;
    have  = 0;
    found = 0;
    xu    = it.except_used;
    xi    = it.except_index;
    ei    = it.entry_index;
    r     = '0;
    r.status = ST_NONE;
    case (it.opcode)
      OP_LOOKUP: begin
        for (int i = 0; i < n; i++)
          if (sel < 0 && valid_m[i] && frames_m[i] == it.frame_number && !(xu && i == xi))
            sel = i;
        r.status = (sel >= 0) ? ST_OK : ST_NONE;
      end
      OP_VICTIM: begin
        // first free entry wins, else the oldest, ties to the lowest index
        for (int i = 0; i < n; i++) begin
          if (!(xu && i == xi) && !found) begin
            if (!valid_m[i]) begin
              sel   = i;
              found = 1;
            end else if (!have || ages_m[i] > ages_m[best]) begin
              best = i;
              have = 1;
            end
          end
        end
        if (!found && have)
          sel = best;
        r.status = (sel >= 0) ? ST_OK : ST_NONE;
      end
      OP_AGE: begin
        for (int i = 0; i < n; i++) begin
          if (xu && i == xi)
            ages_m[i] = '0;
          else if (ages_m[i] != '1)
            ages_m[i] = ages_m[i] + 16'd1;
        end
        r.status = ST_OK;
      end
      OP_WRITE: begin
        if (ei >= n) begin
          r.status = ST_RANGE;
        end else begin
          frames_m[ei] = it.frame_number;
          valid_m[ei]  = 1'b1;
          ages_m[ei]   = '0;
          sel          = ei;
          r.status     = ST_OK;
        end
      end
      OP_READ: begin
        if (ei >= n) begin
          r.status = ST_RANGE;
        end else begin
          sel      = ei;
          r.status = ST_OK;
        end
      end
      default: r.status = ST_NONE;
    endcase
    if (sel >= 0) begin
      r.found_index = sel[3:0];
      r.entry_frame = frames_m[sel];
      r.entry_valid = valid_m[sel];
      r.entry_age   = ages_m[sel];
    end
    return r;
  endfunction

  function automatic op_item_t make_op(logic [2:0] op, logic [31:0] fn, logic [3:0] ei,
                                       logic [3:0] xi, logic xu);
    op_item_t it;
    it.opcode       = op;
    it.frame_number = fn;
    it.entry_index  = ei;
    it.except_index = xi;
    it.except_used  = xu;
    return it;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    errors++;
  endtask

  task automatic check_beat(input logic [OUT_W-1:0] beat);
    result_t got;
    result_t want;
    got = result_t'(beat[$bits(result_t)-1:0]);
    if (pending_results.size() == 0) begin
      $display("%0t: result beat %0h with nothing expected", $time, beat);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_field("status", 32'(want.status), 32'(got.status));
    if (got.found_index !== want.found_index)
      report_field("found_index", 32'(want.found_index), 32'(got.found_index));
    if (got.entry_frame !== want.entry_frame)
      report_field("entry_frame", want.entry_frame, got.entry_frame);
    if (got.entry_valid !== want.entry_valid)
      report_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
    if (got.entry_age !== want.entry_age)
      report_field("entry_age", 32'(want.entry_age), 32'(got.entry_age));
  endtask

  // result side: random stall after each beat taken
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        check_beat(m_tdata);
        stall = draw_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // one beat in; valid stays high into the next beat when there is no gap
  task automatic send_op(input op_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'(it);
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(table_apply(it));
  endtask

  task automatic settle_table();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_active(input logic [4:0] value);
    settle_table();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen    <= 1'b0;
    active_cnt = value;
  endtask

  task automatic test_directed_ops();
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_LOOKUP, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_WRITE,  32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_WRITE,  32'hFFFF_FFFF, 4'd15, 4'd15, 1'b1));
    send_op(make_op(OP_WRITE,  32'hA5A5_5A5A, 4'd7, 4'd0, 1'b0));
    send_op(make_op(OP_LOOKUP, 32'h0, 4'd15, 4'd15, 1'b1));
    send_op(make_op(OP_LOOKUP, 32'hFFFF_FFFF, 4'd0, 4'd0, 1'b0));
    // only match is excluded, so nothing found
    send_op(make_op(OP_LOOKUP, 32'h0, 4'd0, 4'd0, 1'b1));
    send_op(make_op(OP_AGE,    32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_AGE,    32'hFFFF_FFFF, 4'd15, 4'd15, 1'b1));
    send_op(make_op(OP_READ,   32'h0, 4'd15, 4'd0, 1'b0));
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd1, 1'b1));
    send_op(make_op(OP_WRITE,  32'h0, 4'd3, 4'd0, 1'b0));
    send_op(make_op(OP_LOOKUP, 32'h0, 4'd0, 4'd0, 1'b1));
    for (int op = int'(OP_READ) + 1; op <= OPCODE_MAX; op++)
      send_op(make_op(op[2:0], 32'hFFFF_FFFF, 4'd15, 4'd15, 1'b1));
    send_op(make_op(OP_READ,   32'h0, 4'd3, 4'd0, 1'b0));
  endtask

  task automatic test_active_limits();
    // nothing takes part with zero entries
    set_active(5'd0);
    send_op(make_op(OP_LOOKUP, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_AGE,    32'h0, 4'd0, 4'd0, 1'b1));
    send_op(make_op(OP_WRITE,  32'h1234_5678, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    set_active(5'd1);
    send_op(make_op(OP_WRITE,  32'h5555_AAAA, 4'd1, 4'd0, 1'b0));
    send_op(make_op(OP_WRITE,  32'h5555_AAAA, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd0, 1'b1));
    // touch index beyond the active range clears nothing
    send_op(make_op(OP_AGE,    32'h0, 4'd0, 4'd5, 1'b1));
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    // counts above the table size clamp to the full table
    set_active(5'd31);
    send_op(make_op(OP_WRITE,  32'h8000_0001, 4'd15, 4'd0, 1'b0));
    send_op(make_op(OP_READ,   32'h0, 4'd15, 4'd0, 1'b0));
    set_active(5'd17);
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd15, 1'b1));
    send_op(make_op(OP_LOOKUP, 32'h8000_0001, 4'd0, 4'd0, 1'b0));
  endtask

  task automatic test_age_repeat();
    // one active entry keeps each aging pass short
    set_active(5'd1);
    no_idle = 1;
    send_op(make_op(OP_WRITE, 32'hDEAD_0000, 4'd0, 4'd0, 1'b0));
    repeat (40)
      send_op(make_op(OP_AGE, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_VICTIM, 32'h0, 4'd0, 4'd0, 1'b0));
    send_op(make_op(OP_AGE,    32'h0, 4'd0, 4'd0, 1'b1));
    send_op(make_op(OP_READ,   32'h0, 4'd0, 4'd0, 1'b0));
    no_idle = 0;
    set_active(5'd16);
  endtask

  function automatic logic [31:0] pick_frame();
    if ($urandom_range(0, 9) < 6)
      return frame_pool[3'($urandom_range(0, 7))];
    return $urandom();
  endfunction

  function automatic logic [3:0] pick_index();
    int lim;
    lim = active_limit();
    if (lim == 0 || $urandom_range(0, 9) < 3)
      return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, lim - 1));
  endfunction

  task automatic test_random_traffic();
    logic [4:0] phase_active[11];
    logic [2:0] op;
    int         pick;
    int         count;
    phase_active = '{5'd16, 5'd4, 5'd16, 5'd1, 5'd31, 5'd0, 5'd16, 5'd9, 5'd17, 5'd2, 5'd16};
    frame_pool[0] = 32'h0;
    frame_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++)
      frame_pool[i] = $urandom();
    for (int ph = 0; ph < 11; ph++) begin
      set_active(phase_active[ph]);
      no_idle = (ph == 2 || ph == 6);
      count = (phase_active[ph] == 5'd0) ? 20 : 100;
      for (int k = 0; k < count; k++) begin
        // hold off until the table drains, once, halfway through the first phase
        if (ph == 0 && k == count / 2)
          settle_table();
        pick = $urandom_range(0, 99);
        if (pick < 20)      op = OP_LOOKUP;
        else if (pick < 35) op = OP_VICTIM;
        else if (pick < 55) op = OP_AGE;
        else if (pick < 80) op = OP_WRITE;
        else if (pick < 95) op = OP_READ;
        else                op = 3'($urandom_range(int'(OP_READ) + 1, OPCODE_MAX));
        send_op(make_op(op, pick_frame(), pick_index(), pick_index(),
                        1'($urandom_range(0, 1))));
      end
    end
    no_idle = 0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      frames_m[i] = '0;
      valid_m[i]  = 1'b0;
      ages_m[i]   = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_active_limits();
    test_age_repeat();
    test_random_traffic();
    settle_table();
    repeat (SETTLE_CYC) @(posedge clk);
    if (errors == 0)
      $display("frame_table_lru: match");
    else
      $display("frame_table_lru: mismatch");
    $finish;
  end

endmodule
